// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Number of cells in the chain, which is the queue capacity
  localparam int DEPTH = 8;
  // Width of the fill count, able to hold DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int ID_W    = 16;
  localparam int PRI_W   = 8;
  localparam int ECOUNT_W = 4;

  // Operation codes carried on in_kind
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // One held entry
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // Chain-wide command broadcast to every cell
  typedef struct packed {
    logic enq;  // insert the new entry in sorted place
    logic deq;  // shift every entry one cell toward the head
  } cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps its entry, takes the new entry, or
// takes a neighbor's entry, depending on where the new entry belongs.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,    // this cell holds a live entry
  input  entry_t    new_entry,   // entry being enqueued
  input  entry_t    left_entry,  // neighbor toward the head (index - 1)
  input  logic      left_stay,   // neighbor keeps its entry on enqueue
  input  entry_t    right_entry, // neighbor toward the back (index + 1)
  output entry_t    entry,
  output logic      stay
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Keep the entry when it is live and not served after the new one
  assign stay = occupied && (entry_r.pri <= new_entry.pri);

  // Pick the next content of this slot
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.deq) begin
      entry_nxt = right_entry;
    end else if (ctl.enq && !stay) begin
      if (left_stay) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a chain of cells, smallest priority
// at the head, equal priorities in arrival order.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken at each rising edge with start high and busy
// low; busy is high only during reset and until the first rising edge after
// it, so from then on one transaction is taken every cycle. Its result
// appears on the out_ ports for exactly one cycle, in the cycle after
// acceptance, marked by out_valid, and cannot be held off.
// Every cell compares its priority with the new entry in parallel and moves
// one step, so an enqueue or a dequeue updates every cell at once whatever the
// fill level. An enqueue on a full queue or a dequeue on an empty one returns
// out_rejected with zero entry fields. out_entry_count carries the low four
// bits of the fill count after the transaction.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_kind,
  input  logic [ID_W-1:0]     in_new_patient_id,
  input  logic [PRI_W-1:0]    in_new_priority,
  output logic                out_valid,
  output logic [ID_W-1:0]     out_patient_id,
  output logic [PRI_W-1:0]    out_priority,
  output logic                out_served,
  output logic                out_rejected,
  output logic [ECOUNT_W-1:0] out_entry_count
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             busy_r;
  logic             valid_r;
  entry_t           res_r, res_nxt;
  logic             served_r, served_nxt;
  logic             rejected_r, rejected_nxt;

  logic       accept;
  logic       full;
  logic       empty;
  cell_ctl_t  ctl;
  entry_t     new_entry;
  entry_t     cell_entry [DEPTH];
  logic       cell_stay  [DEPTH];

  assign accept = start && !busy_r;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  assign new_entry.id  = in_new_patient_id;
  assign new_entry.pri = in_new_priority;

  // Broadcast the command; drop it when it cannot complete
  assign ctl.enq = accept && (in_kind == KIND_ENQ) && !full;
  assign ctl.deq = accept && (in_kind == KIND_DEQ) && !empty;

  // Build the chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_s;
    entry_t right_e;

    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_s = 1'b1;
    end else begin : g_body
      assign left_e = cell_entry[i-1];
      assign left_s = cell_stay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CNT_W'(i) < count_r),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_stay   (left_s),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .stay        (cell_stay[i])
    );
  end

  // Next fill count and result fields
  always_comb begin
    count_nxt    = count_r;
    res_nxt      = '0;
    served_nxt   = 1'b0;
    rejected_nxt = 1'b0;
    if (accept) begin
      case (in_kind)
        KIND_ENQ: begin
          if (full) begin
            rejected_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        KIND_DEQ: begin
          if (empty) begin
            rejected_nxt = 1'b1;
          end else begin
            count_nxt  = count_r - CNT_W'(1);
            res_nxt    = cell_entry[0];
            served_nxt = 1'b1;
          end
        end
        default: begin
          rejected_nxt = 1'b1;
        end
      endcase
    end
  end

  // Hold control state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      busy_r     <= 1'b1;
      valid_r    <= 1'b0;
      served_r   <= 1'b0;
      rejected_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      busy_r     <= 1'b0;
      valid_r    <= accept;
      served_r   <= served_nxt;
      rejected_r <= rejected_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign busy            = busy_r;
  assign out_valid       = valid_r;
  assign out_patient_id  = res_r.id;
  assign out_priority    = res_r.pri;
  assign out_served      = served_r;
  assign out_rejected    = rejected_r;
  assign out_entry_count = ECOUNT_W'(count_r);

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [ID_W-1:0]     out_patient_id,
  input logic [PRI_W-1:0]    out_priority,
  input logic                out_served,
  input logic                out_rejected
);

  // Each accepted transaction yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted transaction produced no result");

  // No result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted transaction");

  // A result is never both served and rejected
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_served && out_rejected))
    else $error("served and rejected together");

  // Entry fields are zero unless an entry was served
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_served) |-> (out_patient_id == '0 && out_priority == '0))
    else $error("entry fields nonzero without service");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_patient_id (out_patient_id),
  .out_priority   (out_priority),
  .out_served     (out_served),
  .out_rejected   (out_rejected)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted priority queue. A clocked driver plays a
// schedule of enqueue, dequeue and idle cycles; a mirror of the sorted store
// predicts every outcome, and a clocked monitor checks each strobed result
// field by field. Directed cases cover full, empty, ties and field extremes;
// random bursts steer the fill level between empty and full.
// ----------------------------------------------------------------------------
module testbench
  import spq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_OPS   = 650;   // per idling phase, three phases
  localparam int DRAIN_CYCLES = 4;

  // One scheduled cycle: either an idle cycle or a transaction to offer
  typedef struct packed {
    logic             idle;
    logic             kind;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } sched_op_t;

  // What one transaction returns
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PRI_W-1:0]    pri;
    logic                served;
    logic                rejected;
    logic [ECOUNT_W-1:0] count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_kind = KIND_ENQ;
  logic [ID_W-1:0] in_new_patient_id = '0;
  logic [PRI_W-1:0] in_new_priority = '0;

  logic busy;
  logic out_valid;
  logic [ID_W-1:0] out_patient_id;
  logic [PRI_W-1:0] out_priority;
  logic out_served;
  logic out_rejected;
  logic [ECOUNT_W-1:0] out_entry_count;

  sched_op_t op_schedule[$];
  outcome_t  due_outcomes[$];

  // Mirror of the sorted store
  entry_t mirror_slots[DEPTH];
  int     mirror_count = 0;

  int fail_cnt  = 0;
  int cycle_cnt = 0;

  sorted_priority_queue u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_new_patient_id(in_new_patient_id),
    .in_new_priority (in_new_priority),
    .out_valid       (out_valid),
    .out_patient_id  (out_patient_id),
    .out_priority    (out_priority),
    .out_served      (out_served),
    .out_rejected    (out_rejected),
    .out_entry_count (out_entry_count)
  );

  always #1 clk = ~clk;

  // Apply one transaction to the mirror and return its outcome
  function automatic outcome_t apply_triage(logic kind, logic [ID_W-1:0] nid,
                                            logic [PRI_W-1:0] npri);
    outcome_t r;
    int pos;
    int k;
    r = '0;
    if (kind == KIND_ENQ) begin
      if (mirror_count >= DEPTH) begin
        r.rejected = 1'b1;
      end else begin
        // shift every strictly larger priority one slot back
        pos = mirror_count;
        while (pos > 0 && mirror_slots[pos-1].pri > npri) begin
          mirror_slots[pos] = mirror_slots[pos-1];
          pos--;
        end
        mirror_slots[pos].id  = nid;
        mirror_slots[pos].pri = npri;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        r.rejected = 1'b1;
      end else begin
        r.id     = mirror_slots[0].id;
        r.pri    = mirror_slots[0].pri;
        r.served = 1'b1;
        for (k = 0; k + 1 < mirror_count; k++) mirror_slots[k] = mirror_slots[k+1];
        mirror_count--;
      end
    end
    r.count = ECOUNT_W'(mirror_count);
    return r;
  endfunction

  task automatic push_op(logic kind, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
    sched_op_t op;
    op.idle = 1'b0;
    op.kind = kind;
    op.id   = id;
    op.pri  = pri;
    op_schedule.push_back(op);
  endtask

  // Drive: predict each accepted transaction, then offer the next scheduled cycle
  always @(posedge clk) begin : drive
    sched_op_t nxt;
    logic take;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        due_outcomes.push_back(apply_triage(in_kind, in_new_patient_id, in_new_priority));
      end
      if (start && !take) begin
        // hold the offered transaction
      end else if (op_schedule.size() > 0) begin
        nxt = op_schedule.pop_front();
        start             <= !nxt.idle;
        in_kind           <= nxt.kind;
        in_new_patient_id <= nxt.id;
        in_new_priority   <= nxt.pri;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin : check
    outcome_t exp;
    if (rst_n && out_valid) begin
      if (due_outcomes.size() == 0) begin
        $error("result strobed with no transaction outstanding");
        fail_cnt++;
      end else begin
        exp = due_outcomes.pop_front();
        if (out_patient_id !== exp.id) begin
          $error("out_patient_id: expected %h, actual %h", exp.id, out_patient_id);
          fail_cnt++;
        end
        if (out_priority !== exp.pri) begin
          $error("out_priority: expected %h, actual %h", exp.pri, out_priority);
          fail_cnt++;
        end
        if (out_served !== exp.served) begin
          $error("out_served: expected %b, actual %b", exp.served, out_served);
          fail_cnt++;
        end
        if (out_rejected !== exp.rejected) begin
          $error("out_rejected: expected %b, actual %b", exp.rejected, out_rejected);
          fail_cnt++;
        end
        if (out_entry_count !== exp.count) begin
          $error("out_entry_count: expected %0d, actual %0d", exp.count, out_entry_count);
          fail_cnt++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int phase;
    int idle_pct;
    int issued;
    int burst_len;
    int enq_pct;
    int b;
    logic kind;
    logic [PRI_W-1:0] pri;
    sched_op_t gap;

    // Dequeue on empty, then fill with extremes and ties
    push_op(KIND_DEQ, 16'($urandom), 8'($urandom));
    push_op(KIND_ENQ, 16'h0000, 8'hFF);
    push_op(KIND_ENQ, 16'hFFFF, 8'h00);
    push_op(KIND_ENQ, 16'h0001, 8'h80);
    push_op(KIND_ENQ, 16'h0002, 8'h80);
    push_op(KIND_ENQ, 16'h0003, 8'h80);
    push_op(KIND_ENQ, 16'h0004, 8'h00);
    push_op(KIND_ENQ, 16'h0005, 8'hFF);
    push_op(KIND_ENQ, 16'h0006, 8'h7F);
    // Enqueue on full is dropped
    push_op(KIND_ENQ, 16'h0007, 8'h00);
    // Drain in priority order, then one dequeue too many
    for (b = 0; b < DEPTH + 1; b++) push_op(KIND_DEQ, 16'($urandom), 8'($urandom));

    // Random bursts that push the fill level toward full, empty or neither
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 55 : 14;
      issued = 0;
      while (issued < RANDOM_OPS) begin
        burst_len = $urandom_range(4, 40);
        case ($urandom_range(2))
          0: enq_pct = 80;
          1: enq_pct = 20;
          default: enq_pct = 50;
        endcase
        for (b = 0; b < burst_len && issued < RANDOM_OPS; b++) begin
          while ($urandom_range(99) < idle_pct) begin
            gap.idle = 1'b1;
            gap.kind = 1'($urandom);
            gap.id   = 16'($urandom);
            gap.pri  = 8'($urandom);
            op_schedule.push_back(gap);
          end
          kind = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
          // narrow priorities make ties common
          pri = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
          push_op(kind, 16'($urandom), pri);
          issued++;
        end
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the schedule to run out and every result to arrive
    @(posedge clk);
    while (op_schedule.size() != 0 || start || due_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && due_outcomes.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
